// ===== hw/rtl/nms_pkg.sv =====
// ----------------------------------------------------------------------------
// nms_pkg: shared types and constants
// Field widths, direction codes, lane result type and the reset values of
// the two Q2.16 tangent thresholds.
// ----------------------------------------------------------------------------
package nms_pkg;

	localparam int MAG_W     = 16;	// gradient magnitude
	localparam int GRAD_W    = 16;	// signed edge response
	localparam int TAN_W     = 18;	// Q2.16 tangent threshold
	localparam int CODE_W    = 3;
	localparam int CFG_IDX_W = 1;
	localparam int NUM_W     = GRAD_W + 1;		// signed tangent numerator
	localparam int DEN_W     = GRAD_W;			// unsigned denominator, up to 2**15
	localparam int PROD_W    = TAN_W + DEN_W;	// threshold * denominator
	localparam int CMP_W     = PROD_W + 2;		// signed compare width
	localparam int Q16_SH    = 16;

	localparam logic [TAN_W-1:0] LOW_TAN_RST  = TAN_W'(27145);
	localparam logic [TAN_W-1:0] HIGH_TAN_RST = TAN_W'(158217);

	// zero vertical gradient: tangent taken as five
	localparam logic [NUM_W-1:0] NUM_VERT = NUM_W'(5);
	localparam logic [DEN_W-1:0] DEN_ONE  = DEN_W'(1);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_LOW_TAN  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_HIGH_TAN = CFG_IDX_W'(1);

	typedef logic [CODE_W-1:0] code_t;

	// direction codes
	localparam code_t DIR_LOCAL_MAX = code_t'(0);
	localparam code_t DIR_45        = code_t'(1);
	localparam code_t DIR_90        = code_t'(2);
	localparam code_t DIR_135       = code_t'(3);
	localparam code_t DIR_180       = code_t'(4);
	localparam code_t DIR_225       = code_t'(5);
	localparam code_t DIR_270       = code_t'(6);
	localparam code_t DIR_315       = code_t'(7);

	// which side of a direction lane holds a larger neighbor
	typedef enum logic [1:0] {
		SIDE_NONE,
		SIDE_A,
		SIDE_B
	} side_t;

	// findings of the four direction lanes
	typedef struct packed {
		side_t horiz;
		side_t rising;
		side_t vert;
		side_t falling;
	} lanes_t;

endpackage

// ===== hw/rtl/nms_if.sv =====
// ----------------------------------------------------------------------------
// nms_if: window and result channels
// Valid/ready channels; a transfer happens when both are high at a clock edge.
// ----------------------------------------------------------------------------
interface nms_win_if;
	import nms_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MAG_W-1:0]         mag_center;
	logic [MAG_W-1:0]         mag_nw;
	logic [MAG_W-1:0]         mag_n;
	logic [MAG_W-1:0]         mag_ne;
	logic [MAG_W-1:0]         mag_w;
	logic [MAG_W-1:0]         mag_e;
	logic [MAG_W-1:0]         mag_sw;
	logic [MAG_W-1:0]         mag_s;
	logic [MAG_W-1:0]         mag_se;
	logic signed [GRAD_W-1:0] grad_horizontal;
	logic signed [GRAD_W-1:0] grad_vertical;

	modport source (
		output valid, mag_center, mag_nw, mag_n, mag_ne, mag_w, mag_e,
			mag_sw, mag_s, mag_se, grad_horizontal, grad_vertical,
		input  ready
	);
	modport sink (
		input  valid, mag_center, mag_nw, mag_n, mag_ne, mag_w, mag_e,
			mag_sw, mag_s, mag_se, grad_horizontal, grad_vertical,
		output ready
	);
endinterface

interface nms_res_if;
	import nms_pkg::*;

	logic             valid;
	logic             ready;
	logic [MAG_W-1:0] kept_magnitude;
	code_t            direction_code;

	modport source (output valid, kept_magnitude, direction_code, input ready);
	modport sink   (input valid, kept_magnitude, direction_code, output ready);
endinterface

// ===== hw/rtl/canny_nonmax_suppression_top.sv =====
// ----------------------------------------------------------------------------
// canny_nonmax_suppression_top: 3x3 non-maximum suppression
// Classifies the gradient direction of each window and keeps the centre
// magnitude only where it is a local maximum.
// ----------------------------------------------------------------------------
// Usage:
//   win  : one 3x3 window of magnitudes plus centre gradients per transfer.
//   res  : one result per window, in order: kept magnitude, direction code.
//   cfg  : write port for the two Q2.16 tangent thresholds (index 0 low,
//          index 1 high); write only while no window is in flight.
// Timing:
//   Three register stages: lane compares and tangent sign/abs, threshold
//   multiply by |v|, range compare and lane merge into the output register.
//   One window per clock sustained while res is ready; the 18x16 threshold
//   multiplier sits in its own stage so each stage holds one multiply or
//   one wide compare.
// Reset:
//   arst_n clears all stage valids and restores the default thresholds
//   (about 0.4142 and 2.4142).
// Stall:
//   Each stage holds while the next is full and blocked; empty stages keep
//   filling, so up to three windows are taken while res is stalled.
// ----------------------------------------------------------------------------
module canny_nonmax_suppression_top (
	input  logic                            clk,
	input  logic                            arst_n,
	nms_win_if.sink                         win,
	nms_res_if.source                       res,
	input  logic                            cfg_we,
	input  logic [nms_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [nms_pkg::TAN_W-1:0]       cfg_data
);
	import nms_pkg::*;

	logic [TAN_W-1:0] low_tan_q, high_tan_q;

	logic ready_s1, ready_s2, ready_s3;
	logic valid_s1, valid_s2, valid_s3;

	side_t side_h, side_r, side_v, side_f;
	logic signed [NUM_W-1:0] num_c;
	logic [DEN_W-1:0]        den_c;

	lanes_t                  lanes_s1, lanes_s2;
	logic [MAG_W-1:0]        center_s1, center_s2;
	logic signed [NUM_W-1:0] num_s1, num_s2;
	logic [DEN_W-1:0]        den_s1;
	logic [PROD_W-1:0]       prod_low_s2, prod_high_s2;

	logic [MAG_W-1:0] kept_c, kept_s3;
	code_t            code_c, code_s3;

	// threshold registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_tan_q  <= LOW_TAN_RST;
			high_tan_q <= HIGH_TAN_RST;
		end else if (cfg_we) begin
			if (cfg_index == REG_LOW_TAN) begin
				low_tan_q <= cfg_data;
			end
			if (cfg_index == REG_HIGH_TAN) begin
				high_tan_q <= cfg_data;
			end
		end
	end

	// stage handshake: a stage takes new data when empty or draining
	assign ready_s3  = !valid_s3 || res.ready;
	assign ready_s2  = !valid_s2 || ready_s3;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign win.ready = ready_s1;

	// direction lanes, side A listed first
	nms_lane u_lane_horiz (
		.c(win.mag_center), .a0(win.mag_w), .a1(win.mag_nw), .a2(win.mag_sw),
		.b0(win.mag_e), .b1(win.mag_ne), .b2(win.mag_se), .side(side_h)
	);
	nms_lane u_lane_rising (
		.c(win.mag_center), .a0(win.mag_ne), .a1(win.mag_n), .a2(win.mag_e),
		.b0(win.mag_sw), .b1(win.mag_s), .b2(win.mag_w), .side(side_r)
	);
	nms_lane u_lane_vert (
		.c(win.mag_center), .a0(win.mag_n), .a1(win.mag_nw), .a2(win.mag_ne),
		.b0(win.mag_s), .b1(win.mag_sw), .b2(win.mag_se), .side(side_v)
	);
	nms_lane u_lane_falling (
		.c(win.mag_center), .a0(win.mag_nw), .a1(win.mag_n), .a2(win.mag_w),
		.b0(win.mag_se), .b1(win.mag_s), .b2(win.mag_e), .side(side_f)
	);

	// tangent as num/den with den positive
	always_comb begin
		if (win.grad_vertical == '0) begin
			num_c = NUM_VERT;
			den_c = DEN_ONE;
		end else if (win.grad_vertical[GRAD_W-1]) begin
			num_c = -NUM_W'(win.grad_horizontal);
			den_c = DEN_W'(-win.grad_vertical);
		end else begin
			num_c = NUM_W'(win.grad_horizontal);
			den_c = DEN_W'(win.grad_vertical);
		end
	end

	// stage 1: lane results and tangent terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= win.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && win.valid) begin
			lanes_s1  <= '{horiz: side_h, rising: side_r, vert: side_v,
				falling: side_f};
			center_s1 <= win.mag_center;
			num_s1    <= num_c;
			den_s1    <= den_c;
		end
	end

	// stage 2: thresholds scaled by the denominator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			prod_low_s2  <= {{DEN_W{1'b0}}, low_tan_q} * {{TAN_W{1'b0}}, den_s1};
			prod_high_s2 <= {{DEN_W{1'b0}}, high_tan_q} * {{TAN_W{1'b0}}, den_s1};
			lanes_s2     <= lanes_s1;
			center_s2    <= center_s1;
			num_s2       <= num_s1;
		end
	end

	// stage 3: range test and merge into the output register
	nms_merge u_merge (
		.num       (num_s2),
		.prod_low  (prod_low_s2),
		.prod_high (prod_high_s2),
		.lanes     (lanes_s2),
		.center    (center_s2),
		.kept      (kept_c),
		.code      (code_c)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (ready_s3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s3 && valid_s2) begin
			kept_s3 <= kept_c;
			code_s3 <= code_c;
		end
	end

	assign res.valid          = valid_s3;
	assign res.kept_magnitude = kept_s3;
	assign res.direction_code = code_s3;

`ifndef SYNTHESIS
	// a kept magnitude only comes with the local-maximum code
	a_kept_is_max: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && (res.kept_magnitude != '0)) |->
			(res.direction_code == DIR_LOCAL_MAX))
		else $error("kept magnitude with non-maximum direction code");

	// an accepted window lands in stage 1
	a_win_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(win.valid && win.ready) |=> valid_s1)
		else $error("accepted window lost before stage 1");

	// stage 2 advancing fills the output register
	a_s2_to_res: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && ready_s3) |=> res.valid)
		else $error("stage 2 data lost before output");

	// a full, blocked pipeline takes no window
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && !res.ready && valid_s2 && valid_s1) |-> !win.ready)
		else $error("window accepted into a full stalled pipeline");
`endif

endmodule

// ===== hw/rtl/nms_lane.sv =====
// ----------------------------------------------------------------------------
// nms_lane: one direction lane
// Checks the centre against the neighbors on both sides of one direction:
// all three of a side larger first, then only the leading neighbor.
// ----------------------------------------------------------------------------
module nms_lane (
	input  logic [nms_pkg::MAG_W-1:0] c,
	input  logic [nms_pkg::MAG_W-1:0] a0,
	input  logic [nms_pkg::MAG_W-1:0] a1,
	input  logic [nms_pkg::MAG_W-1:0] a2,
	input  logic [nms_pkg::MAG_W-1:0] b0,
	input  logic [nms_pkg::MAG_W-1:0] b1,
	input  logic [nms_pkg::MAG_W-1:0] b2,
	output nms_pkg::side_t            side
);
	import nms_pkg::*;

	logic a_all, b_all;

	assign a_all = (c < a0) && (c < a1) && (c < a2);
	assign b_all = (c < b0) && (c < b1) && (c < b2);

	// priority: full side A, full side B, leading A, leading B
	always_comb begin
		if (a_all) begin
			side = SIDE_A;
		end else if (b_all) begin
			side = SIDE_B;
		end else if (c < a0) begin
			side = SIDE_A;
		end else if (c < b0) begin
			side = SIDE_B;
		end else begin
			side = SIDE_NONE;
		end
	end

endmodule

// ===== hw/rtl/nms_merge.sv =====
// ----------------------------------------------------------------------------
// nms_merge: tangent range test and lane merge
// Compares num*2^16 against +/- threshold*den and picks the first lane, in
// horizontal, rising, vertical, falling order, whose range matches and which
// found a larger neighbor.
// ----------------------------------------------------------------------------
module nms_merge (
	input  logic signed [nms_pkg::NUM_W-1:0]  num,
	input  logic [nms_pkg::PROD_W-1:0]        prod_low,
	input  logic [nms_pkg::PROD_W-1:0]        prod_high,
	input  nms_pkg::lanes_t                   lanes,
	input  logic [nms_pkg::MAG_W-1:0]         center,
	output logic [nms_pkg::MAG_W-1:0]         kept,
	output nms_pkg::code_t                    code
);
	import nms_pkg::*;

	logic signed [CMP_W-1:0] a_cmp;
	logic signed [CMP_W-1:0] p_pos, p_neg, q_pos, q_neg;
	logic in_horiz, in_rising, in_vert, in_falling;
	code_t code_h, code_r, code_v, code_f;

	// scaled numerator and signed thresholds
	assign a_cmp = {{(CMP_W-NUM_W-Q16_SH){num[NUM_W-1]}}, num, {Q16_SH{1'b0}}};
	assign p_pos = signed'({2'b00, prod_low});
	assign q_pos = signed'({2'b00, prod_high});
	assign p_neg = -p_pos;
	assign q_neg = -q_pos;

	// tangent ranges
	assign in_horiz   = (a_cmp >= p_neg) && (a_cmp <= p_pos);
	assign in_rising  = (a_cmp > p_pos) && (a_cmp <= q_pos);
	assign in_vert    = (a_cmp > q_pos) || (a_cmp < q_neg);
	assign in_falling = (a_cmp > q_neg) && (a_cmp <= p_neg);

	// lane side to direction code
	always_comb begin
		case (lanes.horiz)
			SIDE_A:  code_h = DIR_180;
			SIDE_B:  code_h = DIR_90;
			default: code_h = DIR_LOCAL_MAX;
		endcase
		case (lanes.rising)
			SIDE_A:  code_r = DIR_45;
			SIDE_B:  code_r = DIR_225;
			default: code_r = DIR_LOCAL_MAX;
		endcase
		case (lanes.vert)
			SIDE_A:  code_v = DIR_90;
			SIDE_B:  code_v = DIR_270;
			default: code_v = DIR_LOCAL_MAX;
		endcase
		case (lanes.falling)
			SIDE_A:  code_f = DIR_135;
			SIDE_B:  code_f = DIR_315;
			default: code_f = DIR_LOCAL_MAX;
		endcase
	end

	// first matching lane with a larger neighbor wins
	always_comb begin
		code = DIR_LOCAL_MAX;
		if (in_horiz) begin
			code = code_h;
		end
		if ((code == DIR_LOCAL_MAX) && in_rising) begin
			code = code_r;
		end
		if ((code == DIR_LOCAL_MAX) && in_vert) begin
			code = code_v;
		end
		if ((code == DIR_LOCAL_MAX) && in_falling) begin
			code = code_f;
		end
	end

	assign kept = (code == DIR_LOCAL_MAX) ? center : '0;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: canny_nonmax_suppression_top
// Sends 3x3 magnitude windows with centre gradients over the win channel and
// checks every result on the res channel, in order, against a local
// prediction of the tangent classification and the local-maximum test.
// A short table of directed windows and threshold settings comes first
// (extremes, each direction lane, exact tangent boundaries, overlapping
// thresholds). Random windows follow under several threshold settings.
// Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import nms_pkg::*;

	localparam int PIPE_DEPTH  = 3;
	localparam int PHASE_ITEMS = 136;
	localparam int MAX_PRINTS  = 30;
	localparam logic [TAN_W-1:0] TAN_MAX = {TAN_W{1'b1}};

	typedef struct packed {
		logic [MAG_W-1:0]         c;
		logic [MAG_W-1:0]         nw;
		logic [MAG_W-1:0]         n;
		logic [MAG_W-1:0]         ne;
		logic [MAG_W-1:0]         w;
		logic [MAG_W-1:0]         e;
		logic [MAG_W-1:0]         sw;
		logic [MAG_W-1:0]         s;
		logic [MAG_W-1:0]         se;
		logic signed [GRAD_W-1:0] gh;
		logic signed [GRAD_W-1:0] gv;
	} window_t;

	typedef struct packed {
		logic [MAG_W-1:0] kept;
		code_t            code;
	} nms_result_t;

	typedef enum logic {
		ROW_WINDOW,
		ROW_THRESH
	} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		window_t     win;
		logic [TAN_W-1:0] lo;
		logic [TAN_W-1:0] hi;
		bit          known;
		nms_result_t want;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TAN_W-1:0] cfg_data;

	nms_win_if win_ch ();
	nms_res_if res_ch ();

	canny_nonmax_suppression_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.win       (win_ch),
		.res       (res_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// thresholds as the block should hold them
	logic [TAN_W-1:0] low_thr;
	logic [TAN_W-1:0] high_thr;

	nms_result_t pending_results[$];
	stim_row_t   directed_rows[$];
	int          mismatches;
	bit          burst_mode;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// sign of (num/den - thr/65536), den > 0
	function automatic int slope_vs(longint num, longint den, longint thr);
		longint d;
		d = num * 65536 - thr * den;
		if (d > 0)
			return 1;
		if (d < 0)
			return -1;
		return 0;
	endfunction

	// direction lanes in fixed order; the first lane that finds a larger
	// neighbor decides the code
	function automatic nms_result_t suppress_window(window_t x, logic [TAN_W-1:0] lo,
			logic [TAN_W-1:0] hi);
		longint gh, gv, num, den, tl, th;
		code_t code;
		nms_result_t r;
		gh = longint'($signed(x.gh));
		gv = longint'($signed(x.gv));
		tl = longint'(lo);
		th = longint'(hi);
		code = DIR_LOCAL_MAX;
		if (gv == 0) begin
			num = 5;
			den = 1;
		end else if (gv < 0) begin
			num = -gh;
			den = -gv;
		end else begin
			num = gh;
			den = gv;
		end
		// horizontal
		if (slope_vs(num, den, -tl) >= 0 && slope_vs(num, den, tl) <= 0) begin
			if (x.c < x.w && x.c < x.nw && x.c < x.sw) code = DIR_180;
			else if (x.c < x.e && x.c < x.ne && x.c < x.se) code = DIR_90;
			else if (x.c < x.w) code = DIR_180;
			else if (x.c < x.e) code = DIR_90;
		end
		// rising diagonal
		if (code == DIR_LOCAL_MAX && slope_vs(num, den, tl) > 0
				&& slope_vs(num, den, th) <= 0) begin
			if (x.c < x.ne && x.c < x.n && x.c < x.e) code = DIR_45;
			else if (x.c < x.sw && x.c < x.s && x.c < x.w) code = DIR_225;
			else if (x.c < x.ne) code = DIR_45;
			else if (x.c < x.sw) code = DIR_225;
		end
		// vertical
		if (code == DIR_LOCAL_MAX && (slope_vs(num, den, th) > 0
				|| slope_vs(num, den, -th) < 0)) begin
			if (x.c < x.n && x.c < x.nw && x.c < x.ne) code = DIR_90;
			else if (x.c < x.s && x.c < x.sw && x.c < x.se) code = DIR_270;
			else if (x.c < x.n) code = DIR_90;
			else if (x.c < x.s) code = DIR_270;
		end
		// falling diagonal
		if (code == DIR_LOCAL_MAX && slope_vs(num, den, -th) > 0
				&& slope_vs(num, den, -tl) <= 0) begin
			if (x.c < x.nw && x.c < x.n && x.c < x.w) code = DIR_135;
			else if (x.c < x.se && x.c < x.s && x.c < x.e) code = DIR_315;
			else if (x.c < x.nw) code = DIR_135;
			else if (x.c < x.se) code = DIR_315;
		end
		r.code = code;
		r.kept = (code == DIR_LOCAL_MAX && x.c != '0) ? x.c : '0;
		return r;
	endfunction

	task automatic report(string what);
		if (mismatches < MAX_PRINTS)
			$display("%0t: mismatch: %s", $time, what);
		mismatches++;
	endtask

	// ------------------------------------------------------------------------
	// directed table
	// ------------------------------------------------------------------------
	function automatic window_t mk(int c, int nw, int n, int ne, int w, int e, int sw,
			int s, int se, int gh, int gv);
		window_t x;
		x.c = c[MAG_W-1:0];
		x.nw = nw[MAG_W-1:0];
		x.n = n[MAG_W-1:0];
		x.ne = ne[MAG_W-1:0];
		x.w = w[MAG_W-1:0];
		x.e = e[MAG_W-1:0];
		x.sw = sw[MAG_W-1:0];
		x.s = s[MAG_W-1:0];
		x.se = se[MAG_W-1:0];
		x.gh = gh[GRAD_W-1:0];
		x.gv = gv[GRAD_W-1:0];
		return x;
	endfunction

	function automatic void win_row(window_t x);
		stim_row_t r;
		r.kind = ROW_WINDOW;
		r.win = x;
		r.lo = '0;
		r.hi = '0;
		r.known = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void known_row(window_t x, int kept, code_t code);
		stim_row_t r;
		r.kind = ROW_WINDOW;
		r.win = x;
		r.lo = '0;
		r.hi = '0;
		r.known = 1'b1;
		r.want.kept = kept[MAG_W-1:0];
		r.want.code = code;
		directed_rows.push_back(r);
	endfunction

	function automatic void thr_row(logic [TAN_W-1:0] lo, logic [TAN_W-1:0] hi);
		stim_row_t r;
		r.kind = ROW_THRESH;
		r.win = '0;
		r.lo = lo;
		r.hi = hi;
		r.known = 1'b0;
		r.want = '0;
		directed_rows.push_back(r);
	endfunction

	function automatic void build_directed();
		// default thresholds after reset
		known_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, DIR_LOCAL_MAX);
		known_row(mk(65535, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1), 65535, DIR_LOCAL_MAX);
		known_row(mk(0, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 0, 1),
			0, DIR_180);
		known_row(mk(65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535, 65535,
			32767, -32768), 65535, DIR_LOCAL_MAX);
		win_row(mk(100, 0, 0, 200, 50, 200, 0, 0, 200, 3, 100));		// east side
		win_row(mk(100, 0, 0, 0, 101, 0, 0, 0, 0, 0, -7));			// west only
		win_row(mk(10, 0, 11, 11, 0, 11, 0, 0, 0, 1, 1));				// north-east
		win_row(mk(10, 0, 0, 0, 11, 0, 11, 11, 0, -32768, -32768));	// south-west
		win_row(mk(10, 11, 11, 11, 0, 0, 0, 0, 0, -5, 0));			// v zero
		win_row(mk(10, 0, 0, 0, 0, 0, 11, 11, 11, -32768, 1));		// south
		win_row(mk(10, 11, 11, 0, 11, 0, 0, 0, 0, -1, 1));			// north-west
		win_row(mk(10, 0, 0, 0, 0, 11, 0, 11, 11, 32767, -32768));	// south-east
		win_row(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 32767, 1));
		// L = 0.5, H = 2.0: exact boundaries
		thr_row(TAN_W'(32768), TAN_W'(131072));
		// tangent exactly minus H falls into no lane
		known_row(mk(1000, 2000, 2000, 2000, 2000, 2000, 2000, 2000, 2000, -2, 1),
			1000, DIR_LOCAL_MAX);
		win_row(mk(5, 0, 0, 6, 0, 0, 0, 0, 0, 2, 1));
		win_row(mk(5, 0, 0, 0, 6, 0, 0, 0, 0, 1, 2));
		win_row(mk(5, 0, 0, 0, 0, 6, 0, 0, 0, 1, -2));
		// low above high
		thr_row(TAN_MAX, '0);
		win_row(mk(3, 0, 4, 4, 0, 4, 0, 0, 0, 7, 1));
		win_row(mk(3, 4, 4, 4, 4, 4, 4, 4, 4, 0, 0));
		thr_row('0, '0);
		win_row(mk(1, 0, 0, 0, 2, 0, 0, 0, 0, 0, 3));
		win_row(mk(1, 0, 2, 0, 0, 0, 0, 0, 0, 1, 3));
		thr_row(TAN_MAX, TAN_MAX);
		win_row(mk(9, 0, 0, 0, 0, 0, 0, 10, 0, -32768, 1));
		thr_row(LOW_TAN_RST, HIGH_TAN_RST);
	endfunction

	// ------------------------------------------------------------------------
	// random windows
	// ------------------------------------------------------------------------
	function automatic logic [MAG_W-1:0] random_mag(int mode);
		int pick;
		if (mode < 6)
			return MAG_W'($urandom_range(0, 7));
		if (mode < 9)
			return MAG_W'($urandom);
		pick = $urandom_range(0, 3);
		case (pick)
			0: return '0;
			1: return MAG_W'(1);
			2: return MAG_W'(65534);
			default: return MAG_W'(65535);
		endcase
	endfunction

	function automatic logic signed [GRAD_W-1:0] extreme_grad();
		int pick;
		pick = $urandom_range(0, 4);
		case (pick)
			0: return GRAD_W'(-32768);
			1: return GRAD_W'(-1);
			2: return '0;
			3: return GRAD_W'(1);
			default: return GRAD_W'(32767);
		endcase
	endfunction

	function automatic window_t random_window();
		window_t x;
		int mag_mode, grad_mode;
		longint thr, vv, hh;
		mag_mode = $urandom_range(0, 9);
		grad_mode = $urandom_range(0, 9);
		x.c = random_mag(mag_mode);
		x.nw = random_mag(mag_mode);
		x.n = random_mag(mag_mode);
		x.ne = random_mag(mag_mode);
		x.w = random_mag(mag_mode);
		x.e = random_mag(mag_mode);
		x.sw = random_mag(mag_mode);
		x.s = random_mag(mag_mode);
		x.se = random_mag(mag_mode);
		if (grad_mode == 0) begin
			x.gh = GRAD_W'($urandom);
			x.gv = '0;
		end else if (grad_mode < 3) begin
			x.gh = GRAD_W'($urandom_range(0, 8) - 4);
			x.gv = GRAD_W'($urandom_range(0, 8) - 4);
		end else if (grad_mode < 5) begin
			x.gh = GRAD_W'($urandom);
			x.gv = GRAD_W'($urandom);
		end else if (grad_mode == 5) begin
			x.gh = extreme_grad();
			x.gv = extreme_grad();
		end else begin
			// near one of the four tangent boundaries
			thr = $urandom_range(0, 1) ? longint'(low_thr) : longint'(high_thr);
			vv = $urandom_range(0, 1) ? $urandom_range(1, 16) : $urandom_range(1, 32767);
			hh = ((thr * vv) >>> 16) + $urandom_range(0, 2) - 1;
			if (hh > 32767)
				hh = 32767;
			if ($urandom_range(0, 1))
				hh = -hh;
			if ($urandom_range(0, 1)) begin
				hh = -hh;
				vv = -vv;
			end
			x.gh = GRAD_W'(hh);
			x.gv = GRAD_W'(vv);
		end
		return x;
	endfunction

	// ------------------------------------------------------------------------
	// sender side
	// ------------------------------------------------------------------------
	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_window(window_t x, bit known, nms_result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			win_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		win_ch.valid           <= 1'b1;
		win_ch.mag_center      <= x.c;
		win_ch.mag_nw          <= x.nw;
		win_ch.mag_n           <= x.n;
		win_ch.mag_ne          <= x.ne;
		win_ch.mag_w           <= x.w;
		win_ch.mag_e           <= x.e;
		win_ch.mag_sw          <= x.sw;
		win_ch.mag_s           <= x.s;
		win_ch.mag_se          <= x.se;
		win_ch.grad_horizontal <= x.gh;
		win_ch.grad_vertical   <= x.gv;
		@(posedge clk);
		while (!win_ch.ready)
			@(posedge clk);
		// transfer taken at this edge
		pending_results.push_back(known ? want : suppress_window(x, low_thr, high_thr));
	endtask

	// hold off until every result is back and the pipeline is empty
	task automatic drain();
		win_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 1) @(posedge clk);
	endtask

	// write both thresholds; only called with the block idle
	task automatic set_thresholds(logic [TAN_W-1:0] lo, logic [TAN_W-1:0] hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_LOW_TAN;
		cfg_data  <= lo;
		@(posedge clk);
		cfg_index <= REG_HIGH_TAN;
		cfg_data  <= hi;
		@(posedge clk);
		cfg_we    <= 1'b0;
		low_thr  = lo;
		high_thr = hi;
	endtask

	// ------------------------------------------------------------------------
	// result checking
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		nms_result_t want;
		if (arst_n && res_ch.valid === 1'b1 && res_ch.ready) begin
			if (pending_results.size() == 0) begin
				report($sformatf("result with nothing pending: kept %0d code %0d",
					res_ch.kept_magnitude, res_ch.direction_code));
			end else begin
				want = pending_results.pop_front();
				if (res_ch.kept_magnitude !== want.kept)
					report($sformatf("kept_magnitude %0d, predicted %0d",
						res_ch.kept_magnitude, want.kept));
				if (res_ch.direction_code !== want.code)
					report($sformatf("direction_code %0d, predicted %0d",
						res_ch.direction_code, want.code));
			end
		end
	end

	// receiver: ready runs and stalls, sometimes long runs with no stall
	initial begin
		int run, stall, r;
		res_ch.ready = 1'b0;
		forever begin
			run = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(1, 20);
			r = $urandom_range(0, 99);
			if (r < 70)
				stall = $urandom_range(1, 2);
			else if (r < 95)
				stall = $urandom_range(3, 6);
			else
				stall = $urandom_range(10, 40);
			res_ch.ready <= 1'b1;
			repeat (run) @(posedge clk);
			res_ch.ready <= 1'b0;
			repeat (stall) @(posedge clk);
		end
	end

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		logic [TAN_W-1:0] phase_lo[7];
		logic [TAN_W-1:0] phase_hi[7];
		nms_result_t none;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_LOW_TAN;
		cfg_data = '0;
		win_ch.valid = 1'b0;
		win_ch.mag_center = '0;
		win_ch.mag_nw = '0;
		win_ch.mag_n = '0;
		win_ch.mag_ne = '0;
		win_ch.mag_w = '0;
		win_ch.mag_e = '0;
		win_ch.mag_sw = '0;
		win_ch.mag_s = '0;
		win_ch.mag_se = '0;
		win_ch.grad_horizontal = '0;
		win_ch.grad_vertical = '0;
		low_thr = LOW_TAN_RST;
		high_thr = HIGH_TAN_RST;
		mismatches = 0;
		burst_mode = 1'b0;
		none = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		build_directed();
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_THRESH) begin
				drain();
				set_thresholds(directed_rows[i].lo, directed_rows[i].hi);
			end else begin
				send_window(directed_rows[i].win, directed_rows[i].known,
					directed_rows[i].want);
			end
		end

		// random phases under different thresholds
		phase_lo[0] = LOW_TAN_RST;
		phase_hi[0] = HIGH_TAN_RST;
		phase_lo[1] = TAN_W'($urandom_range(0, 131071));
		phase_hi[1] = TAN_W'($urandom_range(phase_lo[1], 262143));
		phase_lo[2] = '0;
		phase_hi[2] = '0;
		phase_lo[3] = TAN_MAX;
		phase_hi[3] = TAN_MAX;
		phase_lo[4] = TAN_MAX;
		phase_hi[4] = '0;
		phase_lo[5] = TAN_W'($urandom);
		phase_hi[5] = TAN_W'($urandom);
		phase_lo[6] = TAN_W'(32768);
		phase_hi[6] = TAN_W'(131072);
		for (int p = 0; p < 7; p++) begin
			drain();
			set_thresholds(phase_lo[p], phase_hi[p]);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if (k % 40 == 0)
					burst_mode = ($urandom_range(0, 3) == 0);
				// mid-phase hold-off until the pipeline has drained
				if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1))
					drain();
				send_window(random_window(), 1'b0, none);
			end
		end

		drain();
		repeat (4 * PIPE_DEPTH) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("PASS canny_nonmax_suppression_top");
		else
			$display("FAIL canny_nonmax_suppression_top");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("FAIL canny_nonmax_suppression_top");
		$finish;
	end

endmodule
